// File: rtl/cksb_pkg.sv
`default_nettype none

package cksb_pkg;

  // Configuration port
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC_SPAN_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_SPAN_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_ENABLE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEY_COLOUR  = 3'd5;

  // Field widths
  localparam int unsigned GEO_W   = 12;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned COORD_W = 11;

  // Stream payloads
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_USED_W  = 4 * COORD_W + PIX_W;

endpackage

`default_nettype wire

// File: rtl/colorkey_stretch_blitter.sv
// An accepted item is registered into the result register and the step state; its result is
// marked valid when the step state ends. No new item is taken while the sequencer is in the
// step state or while the result register holds a result that the output is not taking.
// A geometry write triggers two divisions on the shared bit-serial divider, one per axis, and
// no item is taken until both divisions have finished.
// Reset (asynchronous, active low) clears all registers; the walk starts at the frame origin.
`default_nettype none

module colorkey_stretch_blitter #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [cksb_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [cksb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Source pixels
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [cksb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] src_pixel
  // Destination writes
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [10:0] dest_x, [21:11] dest_y, [37:22] pixel_out, [48:38] next_src_x,
  // [59:49] next_src_y, [63:60] zero
  output logic [cksb_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                     m_axis_tuser,  // [0] write_enable
  output logic                                     m_axis_tlast   // frame_last
);

  localparam int unsigned DW = $clog2(MAX_DIM);
  localparam int unsigned LW = DW + 1;
  localparam int unsigned CO = cksb_pkg::COORD_W;
  localparam int unsigned GW = cksb_pkg::GEO_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DIV_X,
    S_DIV_Y
  } state_e;

  state_e state_q;

  // Configuration
  logic [GW-1:0]               dest_width_q, dest_height_q, span_x_q, span_y_q;
  logic                        key_en_q;
  logic [cksb_pkg::PIX_W-1:0]  key_colour_q;
  logic                        pend_q;

  // Per-axis step constants from the divider
  logic [LW-1:0] qx_q, qy_q;
  logic [DW-1:0] rx_q, ry_q;

  // Walk state
  logic [DW-1:0] dest_col_q, dest_row_q, col_rem_q, row_rem_q, src_col_q, src_row_q;

  // Result register
  logic                       out_valid_q;
  logic [CO-1:0]              out_dx_q, out_dy_q, out_nx_q, out_ny_q;
  logic [cksb_pkg::PIX_W-1:0] out_pix_q;
  logic                       out_we_q;
  logic                       out_last_q;

  logic [LW-1:0] w_len, h_len, sx_len, sy_len;
  logic          geo_wr;
  logic          in_acc;
  logic          empty;

  function automatic logic [LW-1:0] clamp_dim(input logic [GW-1:0] v);
    logic [LW-1:0] r;
    if (32'(v) > 32'(MAX_DIM)) r = LW'(MAX_DIM);
    else                       r = LW'(v);
    return r;
  endfunction

  assign w_len  = clamp_dim(dest_width_q);
  assign h_len  = clamp_dim(dest_height_q);
  assign sx_len = clamp_dim(span_x_q);
  assign sy_len = clamp_dim(span_y_q);
  assign empty  = (w_len == '0) || (h_len == '0);

  assign cfg_ready_o = 1'b1;
  always_comb begin
    unique case (cfg_index_i)
      cksb_pkg::REG_DEST_WIDTH, cksb_pkg::REG_DEST_HEIGHT,
      cksb_pkg::REG_SRC_SPAN_X, cksb_pkg::REG_SRC_SPAN_Y: geo_wr = cfg_valid_i;
      default:                                            geo_wr = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE) && !pend_q && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Shared divider: span / length for one axis at a time
  logic          div_start, div_done;
  logic [LW-1:0] div_quot, div_rem;

  assign div_start = ((state_q == S_IDLE) && pend_q) || ((state_q == S_DIV_X) && div_done);

  cksb_div #(.W(LW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((state_q == S_DIV_X) ? sy_len : sx_len),
    .divisor_i  ((state_q == S_DIV_X) ? h_len : w_len),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Step unit: one remainder add and compare, steered to the column or the row axis.
  logic          row_end, frame_end;
  logic [DW-1:0] acc_rem, acc_r0, acc_src;
  logic [LW-1:0] acc_len, acc_q0, acc_sum;
  logic          acc_carry;
  logic [DW-1:0] rem_new, src_new;

  always_comb begin
    row_end   = ({1'b0, dest_col_q} + LW'(1)) >= w_len;
    frame_end = row_end && (({1'b0, dest_row_q} + LW'(1)) >= h_len);
    acc_rem   = row_end ? row_rem_q : col_rem_q;
    acc_r0    = row_end ? ry_q : rx_q;
    acc_src   = row_end ? src_row_q : src_col_q;
    acc_len   = row_end ? h_len : w_len;
    acc_q0    = row_end ? qy_q : qx_q;
    acc_sum   = {1'b0, acc_rem} + {1'b0, acc_r0};
    acc_carry = acc_sum >= acc_len;
    rem_new   = DW'(acc_carry ? (acc_sum - acc_len) : acc_sum);
    src_new   = DW'({1'b0, acc_src} + acc_q0 + LW'(acc_carry));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dest_width_q  <= '0;
      dest_height_q <= '0;
      span_x_q      <= '0;
      span_y_q      <= '0;
      key_en_q      <= 1'b0;
      key_colour_q  <= '0;
      pend_q        <= 1'b0;
      qx_q          <= '0;
      qy_q          <= '0;
      rx_q          <= '0;
      ry_q          <= '0;
      dest_col_q    <= '0;
      dest_row_q    <= '0;
      col_rem_q     <= '0;
      row_rem_q     <= '0;
      src_col_q     <= '0;
      src_row_q     <= '0;
      out_valid_q   <= 1'b0;
      out_dx_q      <= '0;
      out_dy_q      <= '0;
      out_nx_q      <= '0;
      out_ny_q      <= '0;
      out_pix_q     <= '0;
      out_we_q      <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      pend_q <= geo_wr || (pend_q && !((state_q == S_IDLE) && pend_q));

      unique case (state_q)
        S_IDLE: begin
          if (pend_q) begin
            state_q <= S_DIV_X;
          end else if (in_acc && !empty) begin
            out_dx_q  <= CO'({{CO{1'b0}}, dest_col_q});
            out_dy_q  <= CO'({{CO{1'b0}}, dest_row_q});
            out_pix_q <= s_axis_tdata[cksb_pkg::PIX_W-1:0];
            out_we_q  <= !(key_en_q && (s_axis_tdata[cksb_pkg::PIX_W-1:0] == key_colour_q));
            state_q   <= S_STEP;
          end
        end
        S_STEP: begin
          out_valid_q <= 1'b1;
          out_last_q  <= frame_end;
          if (!row_end) begin
            dest_col_q <= dest_col_q + DW'(1);
            col_rem_q  <= rem_new;
            src_col_q  <= src_new;
            out_nx_q   <= CO'({{CO{1'b0}}, src_new});
            out_ny_q   <= CO'({{CO{1'b0}}, src_row_q});
          end else begin
            dest_col_q <= '0;
            col_rem_q  <= '0;
            src_col_q  <= '0;
            out_nx_q   <= '0;
            if (frame_end) begin
              dest_row_q <= '0;
              row_rem_q  <= '0;
              src_row_q  <= '0;
              out_ny_q   <= '0;
            end else begin
              dest_row_q <= dest_row_q + DW'(1);
              row_rem_q  <= rem_new;
              src_row_q  <= src_new;
              out_ny_q   <= CO'({{CO{1'b0}}, src_new});
            end
          end
          state_q <= S_IDLE;
        end
        S_DIV_X: begin
          if (div_done) begin
            qx_q    <= div_quot;
            rx_q    <= DW'(div_rem);
            state_q <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            qy_q    <= div_quot;
            ry_q    <= DW'(div_rem);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Configuration writes; a geometry write restarts the walk at the frame origin.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          cksb_pkg::REG_DEST_WIDTH:  dest_width_q  <= cfg_data_i[GW-1:0];
          cksb_pkg::REG_DEST_HEIGHT: dest_height_q <= cfg_data_i[GW-1:0];
          cksb_pkg::REG_SRC_SPAN_X:  span_x_q      <= cfg_data_i[GW-1:0];
          cksb_pkg::REG_SRC_SPAN_Y:  span_y_q      <= cfg_data_i[GW-1:0];
          cksb_pkg::REG_KEY_ENABLE:  key_en_q      <= cfg_data_i[0];
          cksb_pkg::REG_KEY_COLOUR:  key_colour_q  <= cfg_data_i[cksb_pkg::PIX_W-1:0];
          default: ;
        endcase
        if (geo_wr) begin
          dest_col_q <= '0;
          dest_row_q <= '0;
          col_rem_q  <= '0;
          row_rem_q  <= '0;
          src_col_q  <= '0;
          src_row_q  <= '0;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cksb_pkg::OUT_TDATA_W - cksb_pkg::OUT_USED_W){1'b0}},
                          out_ny_q, out_nx_q, out_pix_q, out_dy_q, out_dx_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

  a_step_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=> (state_q == S_IDLE))
    else $error("step cycle did not return to idle");

  a_result_from_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_STEP))
    else $error("result appeared without a step cycle");

  a_walk_in_rect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && !empty) |->
      (({1'b0, dest_col_q} < w_len) && ({1'b0, dest_row_q} < h_len)))
    else $error("walk position outside the destination rectangle");

endmodule

`default_nettype wire

// File: rtl/cksb_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cksb_div #(
  parameter int unsigned W = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          ge;

  always_comb begin
    shifted = {acc_q, quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_q};
    ge      = ~diff[W+1];
    acc_d   = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
        cnt_q  <= CW'(W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");

  a_busy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider running with an empty step count");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (div_q != '0)) |-> (acc_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
